FILE: hdl/puv_pkg.sv
// puv_pkg: types and constants of the printable utf-8 validator
// no dependencies; used by printable_utf8_validator_core and puv_step

package puv_pkg;

  localparam int unsigned CodeW = 21;

  localparam logic [7:0] ByteSpace   = 8'h20;
  localparam logic [7:0] ByteDel     = 8'h7f;
  localparam logic [7:0] LeadTwoLo   = 8'hc2;
  localparam logic [7:0] LeadTwoHi   = 8'hdf;
  localparam logic [7:0] LeadThreeLo = 8'he0;
  localparam logic [7:0] LeadThreeHi = 8'hef;
  localparam logic [7:0] LeadFourLo  = 8'hf0;
  localparam logic [7:0] LeadFourHi  = 8'hf4;

  localparam logic [CodeW-1:0] MinThree  = 21'h000800;
  localparam logic [CodeW-1:0] SurrLo    = 21'h00d800;
  localparam logic [CodeW-1:0] SurrHi    = 21'h00dfff;
  localparam logic [CodeW-1:0] MinFour   = 21'h010000;
  localparam logic [CodeW-1:0] MaxCode   = 21'h10ffff;

  localparam logic [1:0] SeqNone  = 2'd0;
  localparam logic [1:0] SeqTwo   = 2'd1;
  localparam logic [1:0] SeqThree = 2'd2;
  localparam logic [1:0] SeqFour  = 2'd3;

  typedef struct packed {
    logic             failed;
    logic [1:0]       pend;
    logic [1:0]       seq_len;
    logic [CodeW-1:0] code;
  } state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } item_t;

endpackage

FILE: hdl/puv_in_if.sv
// puv_in_if: input channel of the validator, at most one text byte per request
// no dependencies

interface puv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last, output ready);
endinterface

FILE: hdl/puv_out_if.sv
// puv_out_if: result channel of the validator, one verdict per text (for the request marked last)
// no dependencies

interface puv_out_if;
  logic valid;
  logic ready;
  logic text_ok;

  modport source (output valid, output text_ok, input ready);
  modport sink   (input valid, input text_ok, output ready);
endinterface

FILE: hdl/printable_utf8_validator_core.sv
// printable_utf8_validator_core: top level of the printable utf-8 validator
// depends on puv_pkg, puv_in_if, puv_out_if and puv_step
//
// Checks a text fed one byte per request and returns one verdict request for
// the request marked last: 1 when the text is well-formed UTF-8 without ASCII
// control characters or DEL, 0 otherwise; an empty text passes. The block
// takes one request per clock cycle for as long as verdicts are taken; a
// verdict is registered: it appears when the last request's item moves from
// the input register into the result register. A last request waits in the
// input register while the previous verdict is stalled. The state update in
// puv_step is combinational.

module printable_utf8_validator_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  puv_in_if.sink            in_i,
  puv_out_if.source         out_o
);

  logic            in_vld_q, in_vld_d;
  puv_pkg::item_t  item_q;
  puv_pkg::state_t state_q, state_d;
  logic            out_vld_q, out_vld_d;
  logic            out_ok_q, out_ok_d;
  logic            verdict;
  logic            adv;
  logic            in_acc;

  puv_step u_step (
    .state_i   (state_q),
    .item_i    (item_q),
    .state_o   (state_d),
    .verdict_o (verdict)
  );

  assign adv        = in_vld_q && (!item_q.last || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d  = in_vld_q;
    out_vld_d = out_vld_q;
    out_ok_d  = out_ok_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    if (adv && item_q.last) begin
      out_vld_d = 1'b1;
      out_ok_d  = verdict;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.data_byte <= in_i.data_byte;
      item_q.has_byte  <= in_i.has_byte;
      item_q.last      <= in_i.last;
    end
    out_ok_q <= out_ok_d;
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.text_ok = out_ok_q;

endmodule

FILE: hdl/puv_step.sv
// puv_step: combinational decode of one item against the running text state
// depends on puv_pkg

module puv_step (
  input  puv_pkg::state_t state_i,
  input  puv_pkg::item_t  item_i,
  output puv_pkg::state_t state_o,
  output logic            verdict_o
);

  puv_pkg::state_t st;
  logic [7:0]      b;

  always_comb begin
    st = state_i;
    b  = item_i.data_byte;
    if (item_i.has_byte && !state_i.failed) begin
      if (state_i.pend == 2'd0) begin
        if (!b[7]) begin
          if (b < puv_pkg::ByteSpace || b == puv_pkg::ByteDel) begin
            st.failed = 1'b1;
          end
        end else if (b >= puv_pkg::LeadTwoLo && b <= puv_pkg::LeadTwoHi) begin
          st.seq_len = puv_pkg::SeqTwo;
          st.code    = {16'd0, b[4:0]};
        end else if (b >= puv_pkg::LeadThreeLo && b <= puv_pkg::LeadThreeHi) begin
          st.seq_len = puv_pkg::SeqThree;
          st.code    = {17'd0, b[3:0]};
        end else if (b >= puv_pkg::LeadFourLo && b <= puv_pkg::LeadFourHi) begin
          st.seq_len = puv_pkg::SeqFour;
          st.code    = {18'd0, b[2:0]};
        end else begin
          st.failed = 1'b1;
        end
        if (!st.failed && b[7]) begin
          st.pend = st.seq_len;
        end
      end else if (b[7:6] != 2'b10) begin
        st.failed = 1'b1;
      end else begin
        st.code = {state_i.code[14:0], b[5:0]};
        st.pend = state_i.pend - 2'd1;
        if (st.pend == 2'd0) begin
          if (state_i.seq_len == puv_pkg::SeqThree &&
              (st.code < puv_pkg::MinThree ||
               (st.code >= puv_pkg::SurrLo && st.code <= puv_pkg::SurrHi))) begin
            st.failed = 1'b1;
          end
          if (state_i.seq_len == puv_pkg::SeqFour &&
              (st.code < puv_pkg::MinFour || st.code > puv_pkg::MaxCode)) begin
            st.failed = 1'b1;
          end
          st.seq_len = puv_pkg::SeqNone;
          st.code    = '0;
        end
      end
    end
  end

  assign verdict_o = !st.failed && st.pend == 2'd0;
  assign state_o   = item_i.last ? '0 : st;

endmodule

FILE: hdl/puv_checker.sv
// puv_checker: port-level assertions for the printable utf-8 validator
// depends on printable_utf8_validator_core; attached by the bind below

module puv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_text_ok_i
);

  logic [1:0] open_q, open_d;
  logic       in_end;
  logic       out_acc;

  assign in_end  = in_valid_i && in_ready_i && in_last_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    open_d = open_q;
    if (in_end && !out_acc) begin
      open_d = open_q + 2'd1;
    end else if (!in_end && out_acc) begin
      open_d = open_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 2'd0;
    end else begin
      open_q <= open_d;
    end
  end

  // stalled verdict holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_text_ok_i))
    else $error("verdict changed while stalled");

  // no verdict without a finished text
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> open_q != 2'd0)
    else $error("verdict without a closing request");

  // at most two texts in flight
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q != 2'd3)
    else $error("too many open verdicts");

  // both stages full and stalled blocks the input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == 2'd2 && !out_ready_i |-> !in_ready_i)
    else $error("input taken while both stages are full");

endmodule

bind printable_utf8_validator_core puv_checker u_puv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_last_i     (in_i.last),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_text_ok_i (out_o.text_ok)
);
